// ----- rtl/ocd_pkg.sv -----
// ----------------------------------------------------------------------------
// ocd_pkg
// Types, constants and the genetic code table shared by the codon change
// detector and its result queue.
// ----------------------------------------------------------------------------
package ocd_pkg;

  // Base codes as they arrive on the input channel.
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  // Two bases of "AT" as held in the search window.
  localparam logic [3:0] WINDOW_AT = {BASE_A, BASE_T};

  // Longest gene the position counter follows before it holds its value.
  localparam int unsigned MAX_GENE_LEN  = 65536;
  localparam int unsigned POS_LIMIT_INT = ((MAX_GENE_LEN - 1) < 65535) ?
                                          (MAX_GENE_LEN - 1) : 65535;
  localparam logic [15:0] POS_LIMIT     = 16'(POS_LIMIT_INT);

  // Amino acid codes: Ala0 Arg1 Asn2 Asp3 Cys4 Gln5 Glu6 Gly7 His8 Ile9
  // Leu10 Lys11 Met12 Phe13 Pro14 Ser15 Thr16 Trp17 Tyr18 Val19 Stop20.
  localparam logic [4:0] AMINO_STOP = 5'd20;

  // Standard genetic code, indexed by first*16 + second*4 + third.
  localparam logic [4:0] AMINO_ROM [64] = '{
    5'd11, 5'd2,  5'd11, 5'd2,  5'd16, 5'd16, 5'd16, 5'd16,
    5'd1,  5'd15, 5'd1,  5'd15, 5'd9,  5'd9,  5'd12, 5'd9,
    5'd5,  5'd8,  5'd5,  5'd8,  5'd14, 5'd14, 5'd14, 5'd14,
    5'd1,  5'd1,  5'd1,  5'd1,  5'd10, 5'd10, 5'd10, 5'd10,
    5'd6,  5'd3,  5'd6,  5'd3,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd7,  5'd7,  5'd7,  5'd7,  5'd19, 5'd19, 5'd19, 5'd19,
    5'd20, 5'd18, 5'd20, 5'd18, 5'd15, 5'd15, 5'd15, 5'd15,
    5'd20, 5'd4,  5'd17, 5'd4,  5'd10, 5'd13, 5'd10, 5'd13
  };

  // Kind of a result.
  typedef enum logic {
    KIND_FRAME   = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_e;

  // One result as it sits in the result queue.
  typedef struct packed {
    result_kind_e result_kind;
    logic [15:0]  frame_start;
    logic         frame_changed;
    logic [14:0]  changed_codons;
    logic [15:0]  first_change_pos;
    logic         gene_changed;
    logic [14:0]  changed_frames;
    logic         last;
  } result_t;

  // Result queue geometry; two results may enter in one cycle.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Write side of the result queue: up to two results in order.
  typedef struct packed {
    logic [1:0] push_cnt;
    result_t    entry0;
    result_t    entry1;
  } fifo_push_t;

endpackage

// ----- rtl/ocd_channels.sv -----
// ----------------------------------------------------------------------------
// ocd_channels
// Valid/ready channels of the codon change detector: one carries aligned
// base pairs in, the other carries frame and gene results out.
// ----------------------------------------------------------------------------
interface ocd_base_if;
  logic       valid;
  logic       ready;
  logic [1:0] ref_base;
  logic [1:0] alt_base;
  logic       gene_end;

  modport source (output valid, ref_base, alt_base, gene_end, input ready);
  modport sink   (input valid, ref_base, alt_base, gene_end, output ready);
endinterface

interface ocd_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] frame_start;
  logic        frame_changed;
  logic [14:0] changed_codons;
  logic [15:0] first_change_pos;
  logic        gene_changed;
  logic [14:0] changed_frames;
  logic        last;

  modport source (output valid, result_kind, frame_start, frame_changed,
                  changed_codons, first_change_pos, gene_changed,
                  changed_frames, last, input ready);
  modport sink   (input valid, result_kind, frame_start, frame_changed,
                  changed_codons, first_change_pos, gene_changed,
                  changed_frames, last, output ready);
endinterface

// ----- rtl/ocd_result_fifo.sv -----
// ----------------------------------------------------------------------------
// ocd_result_fifo
// Small result queue that takes zero, one or two results per cycle and
// hands out one per cycle at its head while the reader pops it.
// ----------------------------------------------------------------------------
module ocd_result_fifo
  import ocd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fifo_push_t            push_i,
  input  logic                  pop_i,
  output result_t               head_o,
  output logic                  head_valid_o,
  output logic [FIFO_CNT_W-1:0] count_o
);

  result_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic [FIFO_PTR_W-1:0] wr_ptr_next;
  logic                  pop;

  assign wr_ptr_next = wr_ptr_q + FIFO_PTR_W'(1);
  assign pop         = pop_i && (count_q != '0);

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_i.push_cnt);
    rd_ptr_d = pop ? (rd_ptr_q + FIFO_PTR_W'(1)) : rd_ptr_q;
    count_d  = count_q + FIFO_CNT_W'(push_i.push_cnt) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage: the first result goes to the write pointer, the second after it.
  always_ff @(posedge clk_i) begin
    if (push_i.push_cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.entry0;
    end
    if (push_i.push_cnt == 2'd2) begin
      mem_q[wr_ptr_next] <= push_i.entry1;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign head_valid_o = (count_q != '0);
  assign count_o      = count_q;

  // The producer only pushes what fits.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (FIFO_CNT_W'(push_i.push_cnt) + count_q - FIFO_CNT_W'(pop))
      <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // Fill level follows pushes and pops.
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_d))
    else $error("result queue count mismatch");

  // At most two results arrive in one cycle.
  a_push_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push_cnt <= 2'd2)
    else $error("result queue push count out of range");

endmodule

// ----- rtl/orf_codon_change_detector.sv -----
// ----------------------------------------------------------------------------
// orf_codon_change_detector
// Compares the translation of a reference gene and a mutated copy frame by
// frame, reporting changed open reading frames and a per-gene summary.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch_i takes one aligned base pair per request (reference base, mutated
//   base, gene end flag). out_ch_o delivers results: a frame result when a
//   reference stop codon closes an open reading frame, and a summary after
//   the base flagged as gene end. One base pair yields zero, one or two
//   results; last marks the final result of that base pair.
//   A request is registered at the input, evaluated from that register with
//   one genetic code lookup per strand, and its results enter a four-entry
//   result queue whose head drives the output. Throughput is one base pair
//   per cycle, set by the single evaluation stage; it stays at that rate
//   while the queue holds at most two results, so a receiver that stalls
//   fills the queue and the input then stops taking requests until results
//   drain.
//   Reset clears the search state, counters and queue; the block then looks
//   for the first ATG of a new gene. Each gene end also returns it there.
// ----------------------------------------------------------------------------
module orf_codon_change_detector
  import ocd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  ocd_base_if.sink     in_ch_i,
  ocd_result_if.source out_ch_o
);

  // Input register.
  logic       s1_valid_q;
  logic [1:0] s1_ref_q;
  logic [1:0] s1_alt_q;
  logic       s1_end_q;
  logic       s1_fire;
  logic       in_fire;

  // Scan state.
  logic        in_frame_q, in_frame_d;
  logic [3:0]  window_q, window_d;
  logic [1:0]  phase_q, phase_d;
  logic [3:0]  ref_bits_q, ref_bits_d;
  logic [3:0]  alt_bits_q, alt_bits_d;
  logic [15:0] base_pos_q, base_pos_d;
  logic [15:0] open_start_q, open_start_d;
  logic [14:0] diff_cnt_q, diff_cnt_d;
  logic [15:0] first_diff_q, first_diff_d;
  logic [14:0] gene_frames_q, gene_frames_d;
  logic        gene_any_q, gene_any_d;

  // Evaluation results.
  logic [4:0]  ref_amino;
  logic [4:0]  alt_amino;
  logic        frame_emit;
  logic [15:0] pos_minus2;
  result_t     frame_res;
  result_t     summary_res;
  fifo_push_t  push;

  // Result queue.
  result_t               head;
  logic                  head_valid;
  logic [FIFO_CNT_W-1:0] fifo_count;

  // The stage advances when the queue has room for two results.
  assign s1_fire       = s1_valid_q && (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign in_ch_i.ready = !s1_valid_q || s1_fire;
  assign in_fire       = in_ch_i.valid && in_ch_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch_i.ready) begin
      s1_valid_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ref_q <= in_ch_i.ref_base;
      s1_alt_q <= in_ch_i.alt_base;
      s1_end_q <= in_ch_i.gene_end;
    end
  end

  // Codon translation for both strands.
  assign ref_amino  = AMINO_ROM[{ref_bits_q, s1_ref_q}];
  assign alt_amino  = AMINO_ROM[{alt_bits_q, s1_alt_q}];
  assign pos_minus2 = base_pos_q - 16'd2;

  // Next scan state for the base pair held in the input register.
  always_comb begin
    in_frame_d    = in_frame_q;
    window_d      = window_q;
    phase_d       = phase_q;
    ref_bits_d    = ref_bits_q;
    alt_bits_d    = alt_bits_q;
    base_pos_d    = base_pos_q;
    open_start_d  = open_start_q;
    diff_cnt_d    = diff_cnt_q;
    first_diff_d  = first_diff_q;
    gene_frames_d = gene_frames_q;
    gene_any_d    = gene_any_q;
    frame_emit    = 1'b0;

    if (s1_valid_q) begin
      if (!in_frame_q) begin
        // Looking for ATG; the window holds the previous two bases.
        if ((phase_q >= 2'd2) && (window_q == WINDOW_AT) && (s1_ref_q == BASE_G)) begin
          in_frame_d   = 1'b1;
          open_start_d = pos_minus2;
          phase_d      = 2'd0;
          window_d     = 4'd0;
          ref_bits_d   = 4'd0;
          alt_bits_d   = 4'd0;
          diff_cnt_d   = '0;
          first_diff_d = '0;
        end else begin
          window_d = {window_q[1:0], s1_ref_q};
          if (phase_q < 2'd2) begin
            phase_d = phase_q + 2'd1;
          end
        end
      end else if (phase_q < 2'd2) begin
        // Gathering the first two bases of a codon.
        ref_bits_d = {ref_bits_q[1:0], s1_ref_q};
        alt_bits_d = {alt_bits_q[1:0], s1_alt_q};
        phase_d    = phase_q + 2'd1;
      end else begin
        // Third base: compare amino acids or close the frame on a stop.
        if (ref_amino == AMINO_STOP) begin
          frame_emit = 1'b1;
          if (diff_cnt_q != '0) begin
            gene_any_d = 1'b1;
            if (!(&gene_frames_q)) begin
              gene_frames_d = gene_frames_q + 15'd1;
            end
          end
          in_frame_d   = 1'b0;
          window_d     = 4'd0;
          diff_cnt_d   = '0;
          first_diff_d = '0;
        end else if (ref_amino != alt_amino) begin
          if (diff_cnt_q == '0) begin
            first_diff_d = pos_minus2;
          end
          if (!(&diff_cnt_q)) begin
            diff_cnt_d = diff_cnt_q + 15'd1;
          end
        end
        phase_d    = 2'd0;
        ref_bits_d = 4'd0;
        alt_bits_d = 4'd0;
      end

      if (base_pos_q < POS_LIMIT) begin
        base_pos_d = base_pos_q + 16'd1;
      end
    end
  end

  // Result words; the summary sees this base pair's frame update.
  always_comb begin
    frame_res                  = '0;
    frame_res.result_kind      = KIND_FRAME;
    frame_res.frame_start      = open_start_q;
    frame_res.frame_changed    = (diff_cnt_q != '0);
    frame_res.changed_codons   = diff_cnt_q;
    frame_res.first_change_pos = first_diff_q;
    frame_res.last             = !s1_end_q;

    summary_res                = '0;
    summary_res.result_kind    = KIND_SUMMARY;
    summary_res.gene_changed   = gene_any_d;
    summary_res.changed_frames = gene_frames_d;
    summary_res.last           = 1'b1;
  end

  always_comb begin
    push.push_cnt = '0;
    if (s1_fire) begin
      push.push_cnt = {1'b0, frame_emit} + {1'b0, s1_end_q};
    end
    push.entry0 = frame_emit ? frame_res : summary_res;
    push.entry1 = summary_res;
  end

  // State registers; a gene end returns everything to its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q    <= 1'b0;
      window_q      <= '0;
      phase_q       <= '0;
      ref_bits_q    <= '0;
      alt_bits_q    <= '0;
      base_pos_q    <= '0;
      open_start_q  <= '0;
      diff_cnt_q    <= '0;
      first_diff_q  <= '0;
      gene_frames_q <= '0;
      gene_any_q    <= 1'b0;
    end else if (s1_fire) begin
      if (s1_end_q) begin
        in_frame_q    <= 1'b0;
        window_q      <= '0;
        phase_q       <= '0;
        ref_bits_q    <= '0;
        alt_bits_q    <= '0;
        base_pos_q    <= '0;
        open_start_q  <= '0;
        diff_cnt_q    <= '0;
        first_diff_q  <= '0;
        gene_frames_q <= '0;
        gene_any_q    <= 1'b0;
      end else begin
        in_frame_q    <= in_frame_d;
        window_q      <= window_d;
        phase_q       <= phase_d;
        ref_bits_q    <= ref_bits_d;
        alt_bits_q    <= alt_bits_d;
        base_pos_q    <= base_pos_d;
        open_start_q  <= open_start_d;
        diff_cnt_q    <= diff_cnt_d;
        first_diff_q  <= first_diff_d;
        gene_frames_q <= gene_frames_d;
        gene_any_q    <= gene_any_d;
      end
    end
  end

  ocd_result_fifo u_result_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (out_ch_o.valid && out_ch_o.ready),
    .head_o       (head),
    .head_valid_o (head_valid),
    .count_o      (fifo_count)
  );

  // Output channel driven from the queue head.
  assign out_ch_o.valid            = head_valid;
  assign out_ch_o.result_kind      = head.result_kind;
  assign out_ch_o.frame_start      = head.frame_start;
  assign out_ch_o.frame_changed    = head.frame_changed;
  assign out_ch_o.changed_codons   = head.changed_codons;
  assign out_ch_o.first_change_pos = head.first_change_pos;
  assign out_ch_o.gene_changed     = head.gene_changed;
  assign out_ch_o.changed_frames   = head.changed_frames;
  assign out_ch_o.last             = head.last;

  // A gene end leaves the scanner searching from position zero.
  a_gene_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_end_q |=> !in_frame_q && (base_pos_q == '0) && (diff_cnt_q == '0))
    else $error("scan state not cleared after gene end");

  // A summary is always the final result of its base pair.
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid && (out_ch_o.result_kind == KIND_SUMMARY) |-> out_ch_o.last)
    else $error("summary result without last");

  // A frame closes only while a frame is open and on its third codon base.
  a_frame_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_emit |-> in_frame_q && (phase_q == 2'd2))
    else $error("frame closed outside a codon boundary");

  // The position counter never passes its limit.
  a_pos_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_pos_q <= POS_LIMIT)
    else $error("base position beyond limit");

endmodule

// ----- verif/codon_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// codon_result_checker
// Watches both channels of the codon change detector. For every accepted
// base pair request it translates the reference and mutated strands on its
// own and predicts the frame and gene reports. Every accepted result is then
// compared field by field with the oldest predicted report.
// ----------------------------------------------------------------------------
module codon_result_checker
  import ocd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ocd_base_if         pair_ch_i,
  ocd_result_if       result_ch_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o,
  output int unsigned frame_results_o,
  output int unsigned summary_results_o
);

  localparam logic [4:0]  AA_STOP     = 5'd20;
  localparam logic [14:0] COUNT_MAX   = 15'h7FFF;
  localparam int unsigned REPORT_MAX  = 10;

  // Standard genetic code, indexed by {first, second, third} base.
  // Each row holds the four codons that share their first two bases.
  localparam logic [4:0] GENETIC_CODE [64] = '{
    5'd11, 5'd2,  5'd11, 5'd2,    // AAx
    5'd16, 5'd16, 5'd16, 5'd16,   // ACx
    5'd1,  5'd15, 5'd1,  5'd15,   // AGx
    5'd9,  5'd9,  5'd12, 5'd9,    // ATx
    5'd5,  5'd8,  5'd5,  5'd8,    // CAx
    5'd14, 5'd14, 5'd14, 5'd14,   // CCx
    5'd1,  5'd1,  5'd1,  5'd1,    // CGx
    5'd10, 5'd10, 5'd10, 5'd10,   // CTx
    5'd6,  5'd3,  5'd6,  5'd3,    // GAx
    5'd0,  5'd0,  5'd0,  5'd0,    // GCx
    5'd7,  5'd7,  5'd7,  5'd7,    // GGx
    5'd19, 5'd19, 5'd19, 5'd19,   // GTx
    5'd20, 5'd18, 5'd20, 5'd18,   // TAx
    5'd15, 5'd15, 5'd15, 5'd15,   // TCx
    5'd20, 5'd4,  5'd17, 5'd4,    // TGx
    5'd10, 5'd13, 5'd10, 5'd13    // TTx
  };

  // Scan state of the gene being translated.
  logic        in_orf;
  logic [3:0]  atg_window;
  logic [1:0]  base_fill;
  logic [3:0]  ref_partial;
  logic [3:0]  alt_partial;
  logic [15:0] base_pos;
  logic [15:0] orf_start;
  logic [14:0] orf_diff_count;
  logic [15:0] orf_first_diff;
  logic [14:0] gene_diff_orfs;
  logic        gene_diff_any;

  // Reports predicted but not yet seen on the result channel.
  result_t     frame_reports [$];
  int unsigned report_errors;
  int unsigned frames_seen;
  int unsigned summaries_seen;

  // Return to the start of a new gene.
  function automatic void clear_gene();
    in_orf         = 1'b0;
    atg_window     = '0;
    base_fill      = '0;
    ref_partial    = '0;
    alt_partial    = '0;
    base_pos       = '0;
    orf_start      = '0;
    orf_diff_count = '0;
    orf_first_diff = '0;
    gene_diff_orfs = '0;
    gene_diff_any  = 1'b0;
  endfunction

  // Advance the scan by one base pair and queue the reports it causes.
  function automatic void translate_pair(logic [1:0] rb, logic [1:0] ab, logic gend);
    logic [4:0] ref_aa;
    logic [4:0] alt_aa;
    logic       have_frame;
    result_t    frame_rep;
    result_t    gene_rep;

    have_frame = 1'b0;
    frame_rep  = '0;
    gene_rep   = '0;

    if (!in_orf) begin
      // Search for ATG on the reference strand at any offset.
      if (base_fill >= 2'd2 && atg_window == WINDOW_AT && rb == BASE_G) begin
        in_orf         = 1'b1;
        orf_start      = base_pos - 16'd2;
        base_fill      = '0;
        atg_window     = '0;
        ref_partial    = '0;
        alt_partial    = '0;
        orf_diff_count = '0;
        orf_first_diff = '0;
      end else begin
        atg_window = {atg_window[1:0], rb};
        if (base_fill < 2'd2) base_fill++;
      end
    end else if (base_fill < 2'd2) begin
      ref_partial = {ref_partial[1:0], rb};
      alt_partial = {alt_partial[1:0], ab};
      base_fill++;
    end else begin
      // Third base: translate both codons and compare.
      ref_aa = GENETIC_CODE[{ref_partial, rb}];
      alt_aa = GENETIC_CODE[{alt_partial, ab}];
      if (ref_aa == AA_STOP) begin
        have_frame                 = 1'b1;
        frame_rep.result_kind      = KIND_FRAME;
        frame_rep.frame_start      = orf_start;
        frame_rep.frame_changed    = (orf_diff_count != '0);
        frame_rep.changed_codons   = orf_diff_count;
        frame_rep.first_change_pos = orf_first_diff;
        if (orf_diff_count != '0) begin
          gene_diff_any = 1'b1;
          if (gene_diff_orfs != COUNT_MAX) gene_diff_orfs++;
        end
        in_orf         = 1'b0;
        atg_window     = '0;
        orf_diff_count = '0;
        orf_first_diff = '0;
      end else if (ref_aa != alt_aa) begin
        if (orf_diff_count == '0) orf_first_diff = base_pos - 16'd2;
        if (orf_diff_count != COUNT_MAX) orf_diff_count++;
      end
      base_fill   = '0;
      ref_partial = '0;
      alt_partial = '0;
    end

    if (base_pos < POS_LIMIT) base_pos++;

    // The last flag goes on the final report of this request.
    if (gend) begin
      gene_rep.result_kind    = KIND_SUMMARY;
      gene_rep.gene_changed   = gene_diff_any;
      gene_rep.changed_frames = gene_diff_orfs;
      gene_rep.last           = 1'b1;
      if (have_frame) frame_reports.insert(frame_reports.size(), frame_rep);
      frame_reports.insert(frame_reports.size(), gene_rep);
      clear_gene();
    end else if (have_frame) begin
      frame_rep.last = 1'b1;
      frame_reports.insert(frame_reports.size(), frame_rep);
    end
  endfunction

  function automatic string fmt_result(result_t r);
    return $sformatf({"kind=%0d start=%0d chg=%0d codons=%0d first=%0d ",
                      "gchg=%0d frames=%0d last=%0d"},
                     r.result_kind, r.frame_start, r.frame_changed,
                     r.changed_codons, r.first_change_pos, r.gene_changed,
                     r.changed_frames, r.last);
  endfunction

  // Compare one accepted result with the oldest predicted report.
  function automatic void check_report();
    result_t got;
    result_t want;

    got.result_kind      = result_kind_e'(result_ch_i.result_kind);
    got.frame_start      = result_ch_i.frame_start;
    got.frame_changed    = result_ch_i.frame_changed;
    got.changed_codons   = result_ch_i.changed_codons;
    got.first_change_pos = result_ch_i.first_change_pos;
    got.gene_changed     = result_ch_i.gene_changed;
    got.changed_frames   = result_ch_i.changed_frames;
    got.last             = result_ch_i.last;

    if (got.result_kind == KIND_SUMMARY) summaries_seen++;
    else frames_seen++;

    if (frame_reports.size() == 0) begin
      report_errors++;
      if (report_errors <= REPORT_MAX)
        $display("ERROR %0t: result with no report outstanding: %s",
                 $realtime, fmt_result(got));
    end else begin
      want = frame_reports.pop_front();
      if (got.result_kind      !== want.result_kind      ||
          got.frame_start      !== want.frame_start      ||
          got.frame_changed    !== want.frame_changed    ||
          got.changed_codons   !== want.changed_codons   ||
          got.first_change_pos !== want.first_change_pos ||
          got.gene_changed     !== want.gene_changed     ||
          got.changed_frames   !== want.changed_frames   ||
          got.last             !== want.last) begin
        report_errors++;
        if (report_errors <= REPORT_MAX) begin
          $display("ERROR %0t: result mismatch", $realtime);
          $display("  expected %s", fmt_result(want));
          $display("  actual   %s", fmt_result(got));
        end
      end
    end
  endfunction

  // Requests are predicted before results are checked; a result never
  // leaves the block in the cycle its request is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_gene();
      frame_reports.delete();
    end else begin
      if (pair_ch_i.valid && pair_ch_i.ready)
        translate_pair(pair_ch_i.ref_base, pair_ch_i.alt_base, pair_ch_i.gene_end);
      if (result_ch_i.valid && result_ch_i.ready) check_report();
    end
    pending_o         <= frame_reports.size();
    mismatch_count_o  <= report_errors;
    frame_results_o   <= frames_seen;
    summary_results_o <= summaries_seen;
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives genes as streams of aligned base pairs into the codon change
// detector: a few hand-built genes, then random genes built mostly from
// well-formed reading frames with random mutations. Both sides stall in
// random bursts until a calm tail; the checker beside the block judges
// every result.
// ----------------------------------------------------------------------------
module testbench;
  import ocd_pkg::*;

  localparam int unsigned RANDOM_PAIRS    = 1420;
  localparam int unsigned CALM_PAIRS      = 150;
  localparam int unsigned DRAIN_EVERY     = 20;
  localparam int unsigned SETTLE_CYCLES   = 12;

  localparam logic [5:0] CODON_ATG = {BASE_A, BASE_T, BASE_G};
  localparam logic [5:0] CODON_TAA = {BASE_T, BASE_A, BASE_A};
  localparam logic [5:0] CODON_TAG = {BASE_T, BASE_A, BASE_G};
  localparam logic [5:0] CODON_TGA = {BASE_T, BASE_G, BASE_A};

  typedef struct packed {
    logic [1:0] ref_base;
    logic [1:0] alt_base;
    logic       gene_end;
  } base_pair_t;

  logic        clk;
  logic        rst_n;
  logic        calm;
  int unsigned pairs_sent;
  int unsigned genes_built;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned frame_count;
  int unsigned summary_count;
  base_pair_t  gene_q [$];

  ocd_base_if   pair_ch ();
  ocd_result_if result_ch ();

  orf_codon_change_detector dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_ch_i  (pair_ch),
    .out_ch_o (result_ch)
  );

  codon_result_checker result_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .pair_ch_i         (pair_ch),
    .result_ch_i       (result_ch),
    .mismatch_count_o  (mismatches),
    .pending_o         (outstanding),
    .frame_results_o   (frame_count),
    .summary_results_o (summary_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gene building blocks.
  function automatic void push_pair(logic [1:0] rb, logic [1:0] ab);
    gene_q.insert(gene_q.size(), '{ref_base: rb, alt_base: ab, gene_end: 1'b0});
  endfunction

  function automatic void push_codon(logic [5:0] rc, logic [5:0] ac);
    push_pair(rc[5:4], ac[5:4]);
    push_pair(rc[3:2], ac[3:2]);
    push_pair(rc[1:0], ac[1:0]);
  endfunction

  // Flag the newest base pair as the end of the gene.
  function automatic void close_gene();
    base_pair_t tail;
    if (gene_q.size() == 0) push_pair(2'($urandom), 2'($urandom));
    tail = gene_q.pop_back();
    tail.gene_end = 1'b1;
    gene_q.insert(gene_q.size(), tail);
    genes_built++;
  endfunction

  function automatic logic [5:0] mutate_codon(logic [5:0] c);
    logic [5:0] m;
    m = c;
    for (int i = 0; i < 3; i++)
      if ($urandom_range(0, 5) == 0) m[2*i +: 2] = 2'($urandom);
    return m;
  endfunction

  function automatic logic [5:0] random_sense_codon();
    logic [5:0] c;
    do c = 6'($urandom);
    while (c == CODON_TAA || c == CODON_TAG || c == CODON_TGA);
    return c;
  endfunction

  function automatic logic [5:0] random_stop_codon();
    case ($urandom_range(0, 2))
      0:       return CODON_TAA;
      1:       return CODON_TAG;
      default: return CODON_TGA;
    endcase
  endfunction

  // Most genes are runs of reading frames with mutated codons; some frames
  // stay open at the gene end, and a few genes are plain noise.
  function automatic void build_random_gene();
    logic [5:0] c;
    logic [1:0] b;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 30)) push_pair(2'($urandom), 2'($urandom));
    end else begin
      repeat ($urandom_range(0, 3)) begin
        repeat ($urandom_range(0, 5)) begin
          b = 2'($urandom);
          push_pair(b, ($urandom_range(0, 3) == 0) ? 2'($urandom) : b);
        end
        push_codon(CODON_ATG,
                   ($urandom_range(0, 7) == 0) ? mutate_codon(CODON_ATG) : CODON_ATG);
        repeat ($urandom_range(0, 10)) begin
          c = random_sense_codon();
          push_codon(c, mutate_codon(c));
        end
        if ($urandom_range(0, 7) == 0) begin
          // Frame left open, possibly on a partial codon.
          repeat ($urandom_range(0, 2)) push_pair(2'($urandom), 2'($urandom));
        end else begin
          c = random_stop_codon();
          push_codon(c, ($urandom_range(0, 3) == 0) ? 6'($urandom) : c);
        end
      end
      repeat ($urandom_range(0, 3)) push_pair(2'($urandom), 2'($urandom));
    end
    close_gene();
  endfunction

  // Maybe pause first; then offer one request and hold it until taken.
  task automatic send_pair(base_pair_t p);
    if (!calm && $urandom_range(0, 5) == 0) begin
      pair_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    pair_ch.valid    <= 1'b1;
    pair_ch.ref_base <= p.ref_base;
    pair_ch.alt_base <= p.alt_base;
    pair_ch.gene_end <= p.gene_end;
    do @(posedge clk); while (!pair_ch.ready);
    pairs_sent++;
  endtask

  task automatic send_queued();
    while (gene_q.size() > 0) send_pair(gene_q.pop_front());
  endtask

  // Hold off new requests until every predicted report has arrived.
  task automatic wait_for_results();
    pair_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Result side: random stall bursts, none once the run turns calm.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && rst_n && $urandom_range(0, 9) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
    end
  end

  initial begin
    int unsigned random_goal;

    calm        = 1'b0;
    pairs_sent  = 0;
    genes_built = 0;
    pair_ch.valid    <= 1'b0;
    pair_ch.ref_base <= BASE_A;
    pair_ch.alt_base <= BASE_A;
    pair_ch.gene_end <= 1'b0;
    rst_n            <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Synonymous change, then a stop codon in the mutated copy only, then a
    // reference stop on the final base of the gene.
    push_codon(CODON_ATG, CODON_ATG);
    push_codon({BASE_G, BASE_C, BASE_A}, {BASE_G, BASE_C, BASE_C});
    push_codon({BASE_T, BASE_G, BASE_G}, CODON_TGA);
    push_codon(CODON_TAG, CODON_TAG);
    close_gene();
    // A gene with no ATG at all.
    push_pair(BASE_C, BASE_T);
    push_pair(BASE_A, BASE_G);
    close_gene();
    // After a stop the search starts afresh, so the stop's last A must not
    // pair with the following TG; the last frame stays open on a partial codon.
    push_codon(CODON_ATG, CODON_ATG);
    push_codon(CODON_TAA, CODON_TAA);
    push_pair(BASE_T, BASE_T);
    push_pair(BASE_G, BASE_G);
    push_codon(CODON_TAA, CODON_TAA);
    push_codon(CODON_ATG, CODON_ATG);
    push_pair(BASE_C, BASE_A);
    close_gene();
    send_queued();

    // Random genes, draining the result queue now and then.
    random_goal = pairs_sent + RANDOM_PAIRS;
    while (pairs_sent < random_goal) begin
      if (pairs_sent + CALM_PAIRS >= random_goal) calm = 1'b1;
      build_random_gene();
      send_queued();
      if (genes_built % DRAIN_EVERY == 0) wait_for_results();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d base pairs in %0d genes; checked %0d frame and %0d gene reports.",
             pairs_sent, genes_built, frame_count, summary_count);
    $display("Included mutated stops, genes without ATG and open frames at gene end.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #10ms;
    $display("Timeout with %0d reports outstanding.", outstanding);
    $display("== FAIL ==");
    $finish;
  end

endmodule
